/* rtl/core/tmed_pkg.sv */
// shared types and constants for the terminal markup escape decoder
// no dependencies; imported by the front, queue, back and top modules
`default_nettype none

package tmed_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] ByteEsc    = 8'hAC;
  localparam logic [CharW-1:0] ByteAttr1  = 8'h86;
  localparam logic [CharW-1:0] ByteAttr2  = 8'h87;
  localparam logic [CharW-1:0] ByteColor  = 8'h9C;
  localparam logic [CharW-1:0] HexInvalid = 8'hFF;

  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChDollar    = 8'h24;
  localparam logic [CharW-1:0] ChLowerN    = 8'h6E;
  localparam logic [CharW-1:0] ChNewline   = 8'h0A;
  localparam logic [CharW-1:0] ChBang      = 8'h21;
  localparam logic [CharW-1:0] ChStar      = 8'h2A;
  localparam logic [CharW-1:0] ChLowerX    = 8'h78;

  localparam logic [1:0] AttrNone = 2'd0;
  localparam logic [1:0] AttrOne  = 2'd1;
  localparam logic [1:0] AttrTwo  = 2'd2;

  // one queued output job: one byte, or a pair sent first then second
  typedef struct packed {
    logic [CharW-1:0] first;
    logic [CharW-1:0] second;
    logic             pair;
  } tmed_cmd_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } tmed_qstat_t;

endpackage

`default_nettype wire

/* rtl/core/tmed_front.sv */
// front end: accepts characters, tracks escape state, builds output jobs
// depends on tmed_pkg
`default_nettype none

module tmed_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [tmed_pkg::CharW-1:0] in_char_i,
  input  wire logic                    q_full_i,
  output logic                         push_o,
  output tmed_pkg::tmed_cmd_t          cmd_o
);
  import tmed_pkg::*;

  logic             bs_q, bs_d;
  logic             dl_q, dl_d;
  logic [1:0]       attr_q, attr_d;
  logic [CharW-1:0] acc_q, acc_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [CharW-1:0] hv;
  logic [CharW-1:0] acc_n;
  logic [1:0]       cnt_n;
  logic             emit;
  logic             accept;

  always_comb begin
    priority if (in_char_i >= 8'h30 && in_char_i <= 8'h39) begin
      hv = in_char_i - 8'h30;
    end else if (in_char_i >= 8'h41 && in_char_i <= 8'h46) begin
      hv = in_char_i - 8'h37;
    end else if (in_char_i >= 8'h61 && in_char_i <= 8'h66) begin
      hv = in_char_i - 8'h57;
    end else begin
      hv = HexInvalid;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign acc_n      = {acc_q[3:0], 4'b0000} | hv;
  assign cnt_n      = cnt_q + 2'd1;

  always_comb begin
    bs_d   = bs_q;
    dl_d   = dl_q;
    attr_d = attr_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    emit   = 1'b0;
    cmd_o  = '0;
    priority if (bs_q) begin
      bs_d = 1'b0;
      priority if (in_char_i == ChBackslash) begin
        emit = 1'b1; cmd_o.first = ChBackslash;
      end else if (in_char_i == ChLowerN) begin
        emit = 1'b1; cmd_o.first = ChNewline;
      end else if (in_char_i == ChDollar) begin
        emit = 1'b1; cmd_o.first = ChDollar;
      end else begin
        emit = 1'b0;
      end
    end else if (dl_q) begin
      priority if (in_char_i == ChBang) begin
        attr_d = AttrOne;
      end else if (in_char_i == ChStar) begin
        attr_d = AttrTwo;
      end else if (in_char_i == ChLowerX) begin
        cnt_d = 2'd1;
      end else if (cnt_q != 2'd0) begin
        if (cnt_n == 2'd3) begin
          emit         = 1'b1;
          cmd_o.first  = ByteEsc;
          cmd_o.second = acc_n;
          cmd_o.pair   = 1'b1;
          acc_d        = '0;
          cnt_d        = 2'd0;
          dl_d         = 1'b0;
        end else begin
          acc_d = acc_n;
          cnt_d = cnt_n;
        end
      end else begin
        // escape ends; a hex digit applies the pending attribute
        attr_d = AttrNone;
        dl_d   = 1'b0;
        if (hv != HexInvalid && (attr_q == AttrOne || attr_q == AttrTwo)) begin
          emit         = 1'b1;
          cmd_o.first  = (attr_q == AttrOne) ? ByteAttr1 : ByteAttr2;
          cmd_o.second = ByteColor + hv;
          cmd_o.pair   = 1'b1;
        end
      end
    end else begin
      priority if (in_char_i[CharW-1]) begin
        emit         = 1'b1;
        cmd_o.first  = ByteEsc;
        cmd_o.second = in_char_i;
        cmd_o.pair   = 1'b1;
      end else if (in_char_i == ChBackslash) begin
        bs_d = 1'b1;
      end else if (in_char_i == ChDollar) begin
        dl_d = 1'b1;
      end else begin
        emit        = 1'b1;
        cmd_o.first = in_char_i;
      end
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q   <= 1'b0;
      dl_q   <= 1'b0;
      attr_q <= AttrNone;
      acc_q  <= '0;
      cnt_q  <= 2'd0;
    end else if (accept) begin
      bs_q   <= bs_d;
      dl_q   <= dl_d;
      attr_q <= attr_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tmed_queue.sv */
// short job queue between front and back
// depends on tmed_pkg
`default_nettype none

module tmed_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tmed_pkg::tmed_cmd_t push_cmd_i,
  input  wire logic                pop_i,
  output tmed_pkg::tmed_cmd_t      pop_cmd_o,
  output tmed_pkg::tmed_qstat_t    stat_o
);
  import tmed_pkg::*;

  tmed_cmd_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_cmd_o    = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tmed_back.sv */
// back end: drains queued jobs one output word per cycle, while out_ready_i allows, into an output register
// depends on tmed_pkg
`default_nettype none

module tmed_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_empty_i,
  input  wire tmed_pkg::tmed_cmd_t     q_cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [tmed_pkg::CharW-1:0]   out_byte_o,
  output logic                         out_last_o
);
  import tmed_pkg::*;

  logic             vld_q;
  logic [CharW-1:0] byte_q;
  logic             last_q;
  logic             sec_vld_q;
  logic [CharW-1:0] sec_q;
  logic             load_ok;

  assign load_ok     = !vld_q || out_ready_i;
  assign pop_o       = load_ok && !sec_vld_q && !q_empty_i;
  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      sec_vld_q <= 1'b0;
      last_q    <= 1'b0;
      byte_q    <= '0;
      sec_q     <= '0;
    end else if (load_ok) begin
      if (sec_vld_q) begin
        // second word of a pair
        vld_q     <= 1'b1;
        byte_q    <= sec_q;
        last_q    <= 1'b1;
        sec_vld_q <= 1'b0;
      end else if (!q_empty_i) begin
        vld_q     <= 1'b1;
        byte_q    <= q_cmd_i.first;
        last_q    <= !q_cmd_i.pair;
        sec_vld_q <= q_cmd_i.pair;
        sec_q     <= q_cmd_i.second;
      end else begin
        vld_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/terminal_markup_escape_decoder_top.sv */
// a character that makes output is written into the job queue when accepted, and its first word
// then moves into the output register; one character per cycle in while the queue is not full,
// one output word per cycle out while m_axis_tready allows, and a pair gives two output words
// the two-entry job queue sets how far the front runs ahead of the output register
// reset: rst_ni asynchronous active low clears escape state, queue and output valid
`default_nettype none

module terminal_markup_escape_decoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast    // last
);
  import tmed_pkg::*;

  tmed_cmd_t   push_cmd;
  tmed_cmd_t   pop_cmd;
  tmed_qstat_t qstat;
  logic        push;
  logic        pop;

  tmed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .q_full_i   (qstat.full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tmed_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .stat_o     (qstat)
  );

  tmed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (qstat.empty),
    .q_cmd_i     (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty) else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCntW'(QDepth)) else $error("queue count out of range");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |=> m_axis_tvalid)
    else $error("first word of pair not followed by second");
`endif

endmodule

`default_nettype wire

/* dv/terminal_markup_escape_decoder_top_test.sv */
`timescale 1ns / 100ps
// self-checking bench for terminal_markup_escape_decoder_top: directed escapes, then random markup
// streams with random idling on both stream sides; needs tmed_pkg and the decoder rtl only

module terminal_markup_escape_decoder_top_test;
  import tmed_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // a hold entry makes the sender wait until every expected word has come out
  typedef struct packed {
    logic       hold;
    logic [7:0] ch;
  } char_slot_t;

  localparam int unsigned RandChars = 1750;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  char_slot_t pending_chars[$];
  out_word_t  expected_words[$];

  // decoder state mirror
  logic       esc_bs;
  logic       esc_dollar;
  logic [1:0] attr_sel;
  logic [7:0] hex_acc;
  logic [1:0] hex_cnt;

  int n_queued, n_chars, n_words, n_hex, n_attr, n_holds, errors;
  int gap_left, tx_quiet, stall_left, rx_quiet;

  terminal_markup_escape_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] char_in
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast)    // last
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] hex_nibble(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch - "0";
    if (ch >= "A" && ch <= "F") return ch - "A" + 8'd10;
    if (ch >= "a" && ch <= "f") return ch - "a" + 8'd10;
    return HexInvalid;
  endfunction

  function automatic void push_word(logic [7:0] b, logic lst);
    out_word_t w;
    w.data = b;
    w.last = lst;
    expected_words.push_back(w);
  endfunction

  function automatic void push_pair(logic [7:0] a, logic [7:0] b);
    push_word(a, 1'b0);
    push_word(b, 1'b1);
  endfunction

  // expected output words for one accepted character
  function automatic void decode_char(logic [7:0] ch);
    logic [7:0] d;
    logic [1:0] mode;
    d = hex_nibble(ch);
    if (esc_bs) begin
      esc_bs = 1'b0;
      if (ch == ChBackslash) push_word(ChBackslash, 1'b1);
      else if (ch == ChLowerN) push_word(ChNewline, 1'b1);
      else if (ch == ChDollar) push_word(ChDollar, 1'b1);
      return;
    end
    if (esc_dollar) begin
      if (ch == ChBang) begin
        attr_sel = AttrOne;
      end else if (ch == ChStar) begin
        attr_sel = AttrTwo;
      end else if (ch == ChLowerX) begin
        hex_cnt = 2'd1;   // partial value is kept
      end else if (hex_cnt != 2'd0) begin
        hex_acc = (hex_acc << 4) | d;
        hex_cnt = hex_cnt + 2'd1;
        if (hex_cnt == 2'd3) begin
          push_pair(ByteEsc, hex_acc);
          hex_acc = 8'h00;
          hex_cnt = 2'd0;
          esc_dollar = 1'b0;
          n_hex++;
        end
      end else begin
        mode = attr_sel;
        attr_sel = AttrNone;
        esc_dollar = 1'b0;
        if (d != HexInvalid) begin
          if (mode == AttrOne) begin
            push_pair(ByteAttr1, ByteColor + d);
            n_attr++;
          end else if (mode == AttrTwo) begin
            push_pair(ByteAttr2, ByteColor + d);
            n_attr++;
          end
        end
      end
      return;
    end
    if (ch[7]) push_pair(ByteEsc, ch);
    else if (ch == ChBackslash) esc_bs = 1'b1;
    else if (ch == ChDollar) esc_dollar = 1'b1;
    else push_word(ch, 1'b1);
  endfunction

  // mostly short idles, a few long ones, and now and then a stretch with none
  function automatic int idle_len(ref int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_char(logic [7:0] ch);
    char_slot_t s;
    s.hold = 1'b0;
    s.ch = ch;
    pending_chars.push_back(s);
    n_queued++;
  endfunction

  function automatic void add_hold();
    char_slot_t s;
    s.hold = 1'b1;
    s.ch = 8'h00;
    pending_chars.push_back(s);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("A" + r - 10);
    return 8'("a" + r - 16);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : sender
    logic       nxt_valid;
    logic [7:0] nxt_data;
    char_slot_t slot;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tdata);
        n_chars++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_chars.size() > 0) begin
          if (pending_chars[0].hold) begin
            if (expected_words.size() == 0) begin
              void'(pending_chars.pop_front());
              n_holds++;
            end
          end else begin
            slot = pending_chars.pop_front();
            nxt_valid = 1'b1;
            nxt_data = slot.ch;
            gap_left = idle_len(tx_quiet);
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata <= nxt_data;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    out_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_words++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected word: expected none, actual byte %02h last %0b",
                     $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_words.pop_front();
          if (want.data !== m_axis_tdata) begin
            errors++;
            if (errors <= 40)
              $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                       $time, want.data, m_axis_tdata);
          end
          if (want.last !== m_axis_tlast) begin
            errors++;
            if (errors <= 40)
              $display("%0t: last mismatch: expected %0b, actual %0b",
                       $time, want.last, m_axis_tlast);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = idle_len(rx_quiet);
      end
    end
  end

  initial begin
    #18_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int r, s, target;
    logic [7:0] c;
    esc_bs = 1'b0;
    esc_dollar = 1'b0;
    attr_sel = AttrNone;
    hex_acc = 8'h00;
    hex_cnt = 2'd0;
    n_queued = 0; n_chars = 0; n_words = 0; n_hex = 0; n_attr = 0; n_holds = 0;
    errors = 0; gap_left = 0; tx_quiet = 0; stall_left = 0; rx_quiet = 0;

    // directed: extremes, backslash escapes, literals, attribute modes
    add_char(8'h00); add_char(8'h7F); add_char(8'h80); add_char(8'hFF);
    add_char(ChBackslash); add_char(ChLowerN);
    add_char(ChBackslash); add_char("q");                 // dropped
    // bang, then literal with an invalid second digit; mode survives
    add_char(ChDollar); add_char(ChBang); add_char(ChLowerX); add_char("a"); add_char("Z");
    add_char(ChDollar); add_char("9");
    // repeated x keeps the partial value
    add_char(ChDollar); add_char(ChLowerX); add_char("1"); add_char(ChLowerX);
    add_char("F"); add_char("0");
    add_char(ChDollar); add_char(ChStar); add_char("G");  // not a digit, mode cleared
    add_char(ChDollar); add_char(ChStar); add_char("f");
    add_hold();

    target = n_queued + RandChars;
    s = n_queued + $urandom_range(300, 500);
    while (n_queued < target) begin
      if (n_queued >= s) begin
        add_hold();
        s = n_queued + $urandom_range(300, 500);
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
        do c = 8'($urandom_range(0, 127)); while (c == ChBackslash || c == ChDollar);
        add_char(c);
      end else if (r < 30) begin
        add_char(8'($urandom_range(128, 255)));
      end else if (r < 42) begin
        add_char(ChBackslash);
        case ($urandom_range(0, 3))
          0: add_char(ChBackslash);
          1: add_char(ChLowerN);
          2: add_char(ChDollar);
          default: add_char(8'($urandom_range(0, 255)));
        endcase
      end else if (r < 90) begin
        add_char(ChDollar);
        if ($urandom_range(0, 1)) add_char($urandom_range(0, 1) ? ChBang : ChStar);
        s = s;  // keep hold schedule untouched
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            add_char(ChLowerX);
            add_char(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : rand_hex_char());
            if ($urandom_range(0, 9) == 0) add_char(ChLowerX);
            add_char(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : rand_hex_char());
          end
          5, 6, 7, 8: begin
            add_char(($urandom_range(0, 9) < 7) ? rand_hex_char()
                                                : 8'($urandom_range(0, 255)));
          end
          default: add_char(8'($urandom_range(0, 255)));
        endcase
      end else begin
        add_char(8'($urandom_range(0, 255)));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_chars.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d characters, %0d output words checked, %0d hex literals,",
             n_chars, n_words, n_hex);
    $display("%0d attribute pairs and %0d drain pauses; %0d mismatches", n_attr, n_holds, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
